/* rtl/kele_pkg.sv */
`timescale 1ns / 1ps

package kele_pkg;

    localparam logic [1:0] EV_RELEASE = 2'd0;
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_REPEAT  = 2'd2;

    localparam logic [1:0] KEY_RETURN    = 2'd1;
    localparam logic [1:0] KEY_BACKSPACE = 2'd2;

    localparam logic [1:0] KIND_LEN  = 2'd0;
    localparam logic [1:0] KIND_CHAR = 2'd1;
    localparam logic [1:0] KIND_EOL  = 2'd2;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_LENGTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DIVIDER = 1'd1;

    localparam logic [7:0] DIVIDER_RESET = 8'd3;
    localparam logic [7:0] PRINT_LOW     = 8'h20;
    localparam logic [7:0] PRINT_HIGH    = 8'h7E;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REPORT,
        ST_READ,
        ST_EMIT,
        ST_EOL
    } kele_state_t;

    typedef struct packed {
        logic load_in;
        logic apply;
        logic clr_idx;
        logic rd;
        logic emit_char;
        logic emit_len;
        logic emit_eol;
    } dp_cmd_t;

    typedef struct packed {
        logic is_eol;
        logic need_report;
        logic len_zero;
        logic idx_last;
        logic out_free;
    } dp_stat_t;

endpackage

/* rtl/kele_ctrl.sv */
`timescale 1ns / 1ps

module kele_ctrl
    import kele_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  dp_stat_t    stat,
    output dp_cmd_t     cmd
);

    kele_state_t state_reg;
    kele_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (stat.is_eol) begin
                    state_next = stat.len_zero ? ST_EOL : ST_READ;
                end else if (stat.need_report) begin
                    state_next = ST_REPORT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_REPORT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    state_next = stat.idx_last ? ST_EOL : ST_READ;
                end
            end
            ST_EOL: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            ST_EXEC: begin
                cmd.apply   = !stat.is_eol;
                cmd.clr_idx = 1'b1;
            end
            ST_REPORT: begin
                cmd.emit_len = stat.out_free;
            end
            ST_READ: begin
                cmd.rd = 1'b1;
            end
            ST_EMIT: begin
                cmd.emit_char = stat.out_free;
            end
            ST_EOL: begin
                cmd.emit_eol = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/kele_dp.sv */
`timescale 1ns / 1ps

module kele_dp
    import kele_pkg::*;
#(
    parameter int MAX_LINE = 32
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [1:0]           s_event_value,
    input  logic [1:0]           s_key_class,
    input  logic [7:0]           s_char_byte,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_result_kind,
    output logic [7:0]           m_char_out,
    output logic [5:0]           m_length_out,
    output logic                 m_last,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat
);

    localparam int ADDR_W = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;

    logic [7:0] line_mem [MAX_LINE];

    logic [1:0] ev_reg;
    logic [1:0] cls_reg;
    logic [7:0] ch_reg;
    logic [7:0] rdata_reg;

    logic [5:0] len_reg;
    logic [5:0] len_next;
    logic       ret_seen_reg;
    logic       ret_seen_next;
    logic [7:0] rep_cnt_reg;
    logic [7:0] rep_cnt_next;
    logic [5:0] idx_reg;
    logic [5:0] idx_next;
    logic       report_len_reg;
    logic [7:0] divider_reg;

    logic       wr_en;
    logic [7:0] rep_inc;
    logic       printable;

    logic       m_valid_reg;
    logic [1:0] kind_reg;
    logic [7:0] char_reg;
    logic [5:0] length_reg;
    logic       last_reg;

    assign printable = (ch_reg >= PRINT_LOW) && (ch_reg <= PRINT_HIGH);
    assign rep_inc   = rep_cnt_reg + 8'd1;

    assign stat.is_eol      = (ev_reg == EV_RELEASE) && (cls_reg == KEY_RETURN) && ret_seen_reg;
    assign stat.need_report = report_len_reg && ((ev_reg == EV_RELEASE) || (ev_reg == EV_REPEAT));
    assign stat.len_zero    = (len_reg == 6'd0);
    assign stat.idx_last    = ((idx_reg + 6'd1) == len_reg);
    assign stat.out_free    = !m_valid_reg || m_ready;

    always_comb begin
        len_next      = len_reg;
        ret_seen_next = ret_seen_reg;
        rep_cnt_next  = rep_cnt_reg;
        wr_en         = 1'b0;
        if (cmd.emit_eol) begin
            len_next      = 6'd0;
            ret_seen_next = 1'b0;
            rep_cnt_next  = 8'd0;
        end else if (cmd.apply) begin
            case (ev_reg)
                EV_RELEASE: begin
                    if ((cls_reg == KEY_BACKSPACE) && (len_reg != 6'd0)) begin
                        len_next = len_reg - 6'd1;
                    end else if (printable && (len_reg < 6'(MAX_LINE))) begin
                        wr_en    = 1'b1;
                        len_next = len_reg + 6'd1;
                    end
                end
                EV_PRESS: begin
                    if (cls_reg == KEY_RETURN) begin
                        ret_seen_next = 1'b1;
                    end
                end
                EV_REPEAT: begin
                    if ((cls_reg == KEY_BACKSPACE) && (len_reg != 6'd0)) begin
                        if (rep_inc >= divider_reg) begin
                            len_next     = len_reg - 6'd1;
                            rep_cnt_next = 8'd0;
                        end else begin
                            rep_cnt_next = rep_inc;
                        end
                    end
                end
                default: begin
                    len_next = len_reg;
                end
            endcase
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (cmd.clr_idx) begin
            idx_next = 6'd0;
        end else if (cmd.emit_char) begin
            idx_next = idx_reg + 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg        <= 6'd0;
            ret_seen_reg   <= 1'b0;
            rep_cnt_reg    <= 8'd0;
            idx_reg        <= 6'd0;
            report_len_reg <= 1'b0;
            divider_reg    <= DIVIDER_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            len_reg      <= len_next;
            ret_seen_reg <= ret_seen_next;
            rep_cnt_reg  <= rep_cnt_next;
            idx_reg      <= idx_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_REPORT_LENGTH:  report_len_reg <= cfg_data[0];
                    CFG_REPEAT_DIVIDER: divider_reg    <= cfg_data;
                    default:            divider_reg    <= divider_reg;
                endcase
            end
            if (cmd.emit_char || cmd.emit_len || cmd.emit_eol) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            ev_reg  <= s_event_value;
            cls_reg <= s_key_class;
            ch_reg  <= s_char_byte;
        end
        if (wr_en) begin
            line_mem[len_reg[ADDR_W-1:0]] <= ch_reg;
        end
        if (cmd.rd) begin
            rdata_reg <= line_mem[idx_reg[ADDR_W-1:0]];
        end
        if (cmd.emit_char) begin
            kind_reg   <= KIND_CHAR;
            char_reg   <= rdata_reg;
            length_reg <= 6'd0;
            last_reg   <= 1'b0;
        end else if (cmd.emit_len) begin
            kind_reg   <= KIND_LEN;
            char_reg   <= 8'd0;
            length_reg <= len_reg;
            last_reg   <= 1'b1;
        end else if (cmd.emit_eol) begin
            kind_reg   <= KIND_EOL;
            char_reg   <= 8'd0;
            length_reg <= 6'd0;
            last_reg   <= 1'b1;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = kind_reg;
    assign m_char_out    = char_reg;
    assign m_length_out  = length_reg;
    assign m_last        = last_reg;

endmodule

/* rtl/key_event_line_editor_top.sv */
`timescale 1ns / 1ps

// Line editor driven by translated keyboard events.
// Input channel (s_): one item per event carries the event kind, the key class
// and the first character byte. Result channel (m_): items with a kind, a
// character, a line length and a last flag marking the final result of an event.
// Configuration channel (cfg_): index 0 enables length reports, index 1 sets the
// number of Backspace repeats per deleted character; cfg_ready is always high.
// An edit event passes through the IDLE and EXEC states of the controller, and
// through REPORT as well when a length report follows, which registers the report.
// A Return release after a recorded Return press streams the line from the
// line memory, each character taking a registered memory read in READ and then
// an emit in EMIT that waits for a free output, and then an end-of-line item.
// A new item is taken only when the previous one is fully handed to the output
// register, which can still hold an untaken result at that time.
// When the receiver stalls, the output register holds its item and the
// controller waits. Reset clears the line length, the Return flag, the repeat
// count and the configuration (reports off, divider 3); the line memory is not
// cleared and needs no clearing pass.
module key_event_line_editor_top
    import kele_pkg::*;
#(
    parameter int MAX_LINE = 32
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_event_value,
    input  logic [1:0]           s_key_class,
    input  logic [7:0]           s_char_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_result_kind,
    output logic [7:0]           m_char_out,
    output logic [5:0]           m_length_out,
    output logic                 m_last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    kele_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    kele_dp #(
        .MAX_LINE (MAX_LINE)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_event_value (s_event_value),
        .s_key_class   (s_key_class),
        .s_char_byte   (s_char_byte),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_char_out    (m_char_out),
        .m_length_out  (m_length_out),
        .m_last        (m_last),
        .cmd           (cmd),
        .stat          (stat)
    );

`ifndef SYNTHESIS
    a_char_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_kind == KIND_CHAR) |-> !m_last && (m_length_out == 6'd0))
        else $error("character item marked last or carries a length");

    a_len_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_kind != KIND_CHAR) |-> m_last && (m_char_out == 8'd0))
        else $error("length or end item not last or carries a character");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted again before the item was processed");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_kind == KIND_LEN) |-> m_length_out <= 6'(MAX_LINE))
        else $error("reported line length beyond the limit");
`endif

endmodule
